// ===== hw/rtl/tcspq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcspq_pkg
// Shared types, codes and decode helpers of the three-class priority queue.
// ----------------------------------------------------------------------------
package tcspq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_CLASSES     = 3;

    localparam int ID_W     = 31;
    localparam int TAG_W    = 32;
    localparam int PB_W     = 8;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 2;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SERVED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

    localparam logic [CLASS_W-1:0] CLASS_HIGH = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_MID  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_LOW  = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd3;

    localparam logic [PB_W-1:0] PB_RED    = 8'h52;
    localparam logic [PB_W-1:0] PB_YELLOW = 8'h59;
    localparam logic [PB_W-1:0] PB_GREEN  = 8'h47;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_SERVE = 1'b1;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic load_rd;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic rd_hit;
    } t_sts;

    function automatic logic [CLASS_W-1:0] class_of(input logic [PB_W-1:0] pb);
        logic [CLASS_W-1:0] c;
        unique case (pb)
            PB_RED:    c = CLASS_HIGH;
            PB_YELLOW: c = CLASS_MID;
            PB_GREEN:  c = CLASS_LOW;
            default:   c = CLASS_NONE;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/three_class_strict_priority_queue.sv =====
// ----------------------------------------------------------------------------
// three_class_strict_priority_queue
// Three FIFO classes (high 'R', middle 'Y', low 'G') of QUEUE_DEPTH entries
// each, served in strict priority order.
// ----------------------------------------------------------------------------
// Each input item yields one result item. An add, an invalid byte, a full
// class or a serve of an all-empty queue passes through the accept and
// execute states; a serve that pops an entry also passes a read state, for
// the registered read of the single-port entry store. The result sits in an
// output register, so a new item is accepted while it waits; execution of
// that item holds until the register is taken. tuser in: action; tdata in:
// entry_id, name_tag, priority_byte. tuser out: status; tdata out: served_id,
// served_tag, served_class.
// ----------------------------------------------------------------------------
module three_class_strict_priority_queue
    import tcspq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // entry_id[30:0] name_tag[62:31] priority_byte[70:63]
    input  logic                  i_s_tuser,   // action
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // served_id[30:0] served_tag[62:31] served_class[64:63]
    output logic [STATUS_W-1:0]   o_m_tuser    // status
);

    t_cmd cmd;
    t_sts sts;

    logic [ID_W-1:0]    served_id;
    logic [TAG_W-1:0]   served_tag;
    logic [CLASS_W-1:0] served_class;

    tcspq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_sts      (sts),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    tcspq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_s_tuser),
        .i_entry_id      (i_s_tdata[ID_W-1:0]),
        .i_name_tag      (i_s_tdata[ID_W+TAG_W-1:ID_W]),
        .i_priority_byte (i_s_tdata[ID_W+TAG_W+PB_W-1:ID_W+TAG_W]),
        .o_out_valid     (o_m_tvalid),
        .i_out_ready     (i_m_tready),
        .o_status        (o_m_tuser),
        .o_served_id     (served_id),
        .o_served_tag    (served_tag),
        .o_served_class  (served_class)
    );

    assign o_m_tdata = {{(OUT_DATA_W - ID_W - TAG_W - CLASS_W){1'b0}},
                        served_class, served_tag, served_id};

    a_exec_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |-> sts.out_free)
        else $error("item executed while result register busy");

    a_read_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_rd |-> $past(cmd.exec) && $past(sts.rd_hit))
        else $error("store read result loaded without a serve hit");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !cmd.exec && !cmd.load_rd)
        else $error("input ready while an item is in progress");

    a_unserved_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_SERVED)) |->
            (served_id == '0) && (served_tag == '0) && (served_class == CLASS_NONE))
        else $error("non-serve result carries entry data");

endmodule

// ===== hw/rtl/tcspq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcspq_ctrl
// Sequencer: takes an item, executes it once the result slot is free, and
// steps through a read state for the store read on a serve that finds an entry.
// ----------------------------------------------------------------------------
module tcspq_ctrl
    import tcspq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.latch_in = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_rd  = 1'b0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.rd_hit ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.load_rd = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/tcspq_dp.sv =====
// ----------------------------------------------------------------------------
// tcspq_dp
// Datapath: item register, per-class head/tail/count, entry store and the
// result register.
// ----------------------------------------------------------------------------
module tcspq_dp
    import tcspq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_action,
    input  logic [ID_W-1:0]       i_entry_id,
    input  logic [TAG_W-1:0]      i_name_tag,
    input  logic [PB_W-1:0]       i_priority_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [ID_W-1:0]       o_served_id,
    output logic [TAG_W-1:0]      o_served_tag,
    output logic [CLASS_W-1:0]    o_served_class
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_D   = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_D);
    localparam int ENTRY_W = ID_W + TAG_W;

    logic                 r_action;
    logic [ID_W-1:0]      r_id;
    logic [TAG_W-1:0]     r_tag;
    logic [PB_W-1:0]      r_pb;

    logic [PTR_W-1:0]     r_head  [NUM_CLASSES];
    logic [PTR_W-1:0]     r_tail  [NUM_CLASSES];
    logic [CNT_W-1:0]     r_count [NUM_CLASSES];

    logic [ENTRY_W-1:0]   r_mem [MEM_D];
    logic [ENTRY_W-1:0]   r_rd_data;
    logic [CLASS_W-1:0]   r_rd_class;

    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [ID_W-1:0]      r_out_id;
    logic [TAG_W-1:0]     r_out_tag;
    logic [CLASS_W-1:0]   r_out_class;

    logic [CLASS_W-1:0]   add_cls;
    logic                 add_valid;
    logic                 add_full;
    logic                 add_ok;
    logic [CLASS_W-1:0]   add_sel;
    logic [CLASS_W-1:0]   srv_cls;
    logic                 srv_hit;
    logic [CLASS_W-1:0]   srv_sel;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [STATUS_W-1:0]  ex_status;
    logic                 out_free;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        add_cls   = class_of(r_pb);
        add_valid = (add_cls != CLASS_NONE);
        add_sel   = add_valid ? add_cls : CLASS_HIGH;
        add_full  = (r_count[add_sel] == CNT_W'(QUEUE_DEPTH));
        add_ok    = (r_action == ACT_ADD) && add_valid && !add_full;

        if (r_count[0] != '0) begin
            srv_cls = CLASS_HIGH;
        end else if (r_count[1] != '0) begin
            srv_cls = CLASS_MID;
        end else if (r_count[2] != '0) begin
            srv_cls = CLASS_LOW;
        end else begin
            srv_cls = CLASS_NONE;
        end
        srv_hit = (r_action == ACT_SERVE) && (srv_cls != CLASS_NONE);
        srv_sel = (srv_cls != CLASS_NONE) ? srv_cls : CLASS_HIGH;

        wr_addr = ADDR_W'(add_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_tail[add_sel]);
        rd_addr = ADDR_W'(srv_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(r_head[srv_sel]);

        if (r_action == ACT_SERVE) begin
            ex_status = ST_EMPTY;
        end else if (!add_valid) begin
            ex_status = ST_INVALID;
        end else if (add_full) begin
            ex_status = ST_FULL;
        end else begin
            ex_status = ST_ADDED;
        end

        out_free = !r_out_valid || i_out_ready;
    end

    assign o_sts.out_free = out_free;
    assign o_sts.rd_hit   = srv_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_action <= i_action;
            r_id     <= i_entry_id;
            r_tag    <= i_name_tag;
            r_pb     <= i_priority_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            if (add_ok) begin
                r_tail[add_sel]  <= wrap_next(r_tail[add_sel]);
                r_count[add_sel] <= r_count[add_sel] + CNT_W'(1);
            end else if (srv_hit) begin
                r_head[srv_sel]  <= wrap_next(r_head[srv_sel]);
                r_count[srv_sel] <= r_count[srv_sel] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && add_ok) begin
            r_mem[wr_addr] <= {r_id, r_tag};
        end
        if (i_cmd.exec && srv_hit) begin
            r_rd_data  <= r_mem[rd_addr];
            r_rd_class <= srv_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.exec && !srv_hit) || i_cmd.load_rd) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !srv_hit) begin
            r_out_status <= ex_status;
            r_out_id     <= '0;
            r_out_tag    <= '0;
            r_out_class  <= CLASS_NONE;
        end else if (i_cmd.load_rd) begin
            r_out_status <= ST_SERVED;
            r_out_id     <= r_rd_data[ENTRY_W-1:TAG_W];
            r_out_tag    <= r_rd_data[TAG_W-1:0];
            r_out_class  <= r_rd_class;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_served_id    = r_out_id;
    assign o_served_tag   = r_out_tag;
    assign o_served_class = r_out_class;

endmodule
